@@ sv/srfc_pkg.sv @@
// ----------------------------------------------------------------------------
// srfc_pkg
// Shared constants, status codes and helpers for the touch-screen frame
// receiver: frame limits, tail pattern and the CRC-16/MODBUS byte update.
// ----------------------------------------------------------------------------
package srfc_pkg;

    localparam int MAX_FRAME  = 256;
    localparam int CNT_W      = $clog2(MAX_FRAME + 1);

    localparam logic [7:0] HDR_TOUCH = 8'hCC;
    localparam logic [7:0] HDR_REPLY = 8'hEE;
    localparam logic [7:0] CMD_PAGE  = 8'h06;
    localparam logic [7:0] TAIL_FF   = 8'hFF;
    localparam logic [7:0] TAIL_FC   = 8'hFC;

    localparam int TAIL_LEN   = 4;
    localparam int TAIL_W     = 2;
    localparam int TOUCH_MIN  = 15;
    localparam int REPLY_MIN  = 5;
    localparam int REPLY_LEN  = 7;
    localparam int HEAD_LO    = 2;
    localparam int HEAD_DEPTH = 13;
    localparam int WIN_DEPTH  = 6;
    localparam int CRC_START  = HEAD_LO + WIN_DEPTH;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam int DATA_W = 80;

    typedef enum logic [2:0] {
        ST_TOUCH     = 3'd0,
        ST_PAGE      = 3'd1,
        ST_CRC_BAD   = 3'd2,
        ST_SHORT     = 3'd3,
        ST_IGNORED   = 3'd4,
        ST_BAD_LEN   = 3'd5,
        ST_OVERFLOW  = 3'd6
    } t_status;

    function automatic logic [7:0] tail_byte(input logic [TAIL_W-1:0] pos);
        logic [7:0] b;
        case (pos)
            2'd1:    b = TAIL_FC;
            default: b = TAIL_FF;
        endcase
        return b;
    endfunction

    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

@@ sv/screen_frame_receiver_crc16.sv @@
// ----------------------------------------------------------------------------
// screen_frame_receiver_crc16
// Parses CC (touch) and EE (reply) frames ending in FF FC FF FF from a byte
// stream, checks CRC-16/MODBUS and reports one status item per frame.
// Path: input accept -> input reg -> result reg -> result valid.
// Throughput: one byte per cycle; input stalls only while a result waits on output.
// Reset: synchronous, active low; clears parser state, CRC to 0xFFFF.
// ----------------------------------------------------------------------------
module screen_frame_receiver_crc16 (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // rx_byte
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [srfc_pkg::DATA_W-1:0] o_m_tdata, // page_id, ctrl_id, x_pos, y_pos, touch_event
    output logic [2:0]  o_m_tuser    // status
);

    localparam int CNT_W = srfc_pkg::CNT_W;

    logic                   r_in_valid;
    logic [7:0]             r_in_byte;

    logic                   r_in_frame, n_in_frame;
    logic                   r_touch, n_touch;
    logic [CNT_W-1:0]       r_count, n_count;
    logic [srfc_pkg::TAIL_W-1:0] r_tail, n_tail;
    logic [15:0]            r_crc, n_crc;
    logic [7:0]             r_head [srfc_pkg::HEAD_LO:srfc_pkg::HEAD_DEPTH-1];
    logic [7:0]             r_win  [0:srfc_pkg::WIN_DEPTH-1];

    logic                   r_out_valid;
    srfc_pkg::t_status      r_out_status;
    logic [srfc_pkg::DATA_W-1:0] r_out_data;

    logic                   advance;
    logic                   store;
    logic                   res_valid;
    srfc_pkg::t_status      res_status;
    logic [srfc_pkg::DATA_W-1:0] res_data;
    logic                   crc_ok;
    logic [CNT_W-1:0]       len;

    assign advance    = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || advance;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_status;
    assign o_m_tdata  = r_out_data;

    always_comb begin
        n_in_frame = r_in_frame;
        n_touch    = r_touch;
        n_count    = r_count;
        n_tail     = r_tail;
        n_crc      = r_crc;
        store      = 1'b0;
        res_valid  = 1'b0;
        res_status = srfc_pkg::ST_TOUCH;
        res_data   = '0;
        crc_ok     = 1'b0;
        len        = r_count - CNT_W'(srfc_pkg::TAIL_LEN - 1);

        if (!r_in_frame) begin
            if (r_in_byte inside {srfc_pkg::HDR_TOUCH, srfc_pkg::HDR_REPLY}) begin
                n_in_frame = 1'b1;
                n_touch    = (r_in_byte == srfc_pkg::HDR_TOUCH);
                n_count    = '0;
                n_tail     = '0;
                n_crc      = srfc_pkg::CRC_INIT;
            end
        end else if (r_count >= CNT_W'(srfc_pkg::MAX_FRAME)) begin
            n_in_frame = 1'b0;
            res_valid  = 1'b1;
            res_status = srfc_pkg::ST_OVERFLOW;
        end else begin
            store   = 1'b1;
            n_count = r_count + CNT_W'(1);
            if (r_count >= CNT_W'(srfc_pkg::CRC_START)) begin
                n_crc = srfc_pkg::crc_feed(r_crc, r_win[0]);
            end
            crc_ok = ({r_win[1], r_win[2]} == n_crc);
            if (r_in_byte == srfc_pkg::tail_byte(r_tail)) begin
                if (r_tail == srfc_pkg::TAIL_W'(srfc_pkg::TAIL_LEN - 1)) begin
                    n_in_frame = 1'b0;
                    n_tail     = '0;
                    res_valid  = 1'b1;
                    if (r_touch) begin
                        if (len < CNT_W'(srfc_pkg::TOUCH_MIN)) begin
                            res_status = srfc_pkg::ST_SHORT;
                        end else if (r_head[2] != srfc_pkg::CMD_PAGE) begin
                            res_status = srfc_pkg::ST_IGNORED;
                        end else if (!crc_ok) begin
                            res_status = srfc_pkg::ST_CRC_BAD;
                        end else begin
                            res_status = srfc_pkg::ST_TOUCH;
                            res_data   = {r_head[11], r_head[12], r_head[9], r_head[10],
                                          r_head[7], r_head[8], r_head[5], r_head[6],
                                          r_head[3], r_head[4]};
                        end
                    end else begin
                        if (len < CNT_W'(srfc_pkg::REPLY_MIN)) begin
                            res_status = srfc_pkg::ST_SHORT;
                        end else if (!crc_ok) begin
                            res_status = srfc_pkg::ST_CRC_BAD;
                        end else if (r_head[2] != srfc_pkg::CMD_PAGE) begin
                            res_status = srfc_pkg::ST_IGNORED;
                        end else if (len != CNT_W'(srfc_pkg::REPLY_LEN)) begin
                            res_status = srfc_pkg::ST_BAD_LEN;
                        end else begin
                            res_status = srfc_pkg::ST_PAGE;
                            res_data   = {64'h0, r_head[3], r_head[4]};
                        end
                    end
                end else begin
                    n_tail = r_tail + srfc_pkg::TAIL_W'(1);
                end
            end else begin
                n_tail = (r_in_byte == srfc_pkg::TAIL_FF) ? srfc_pkg::TAIL_W'(1) : '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_in_frame  <= 1'b0;
            r_touch     <= 1'b0;
            r_count     <= '0;
            r_tail      <= '0;
            r_crc       <= srfc_pkg::CRC_INIT;
            r_out_valid <= 1'b0;
        end else begin
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            if (advance) begin
                r_in_frame  <= n_in_frame;
                r_touch     <= n_touch;
                r_count     <= n_count;
                r_tail      <= n_tail;
                r_crc       <= n_crc;
                r_out_valid <= res_valid;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_byte <= i_s_tdata;
        end
        if (advance && res_valid) begin
            r_out_status <= res_status;
            r_out_data   <= res_data;
        end
        if (advance && store) begin
            for (int k = srfc_pkg::HEAD_LO; k < srfc_pkg::HEAD_DEPTH; k++) begin
                if (r_count == CNT_W'(k)) begin
                    r_head[k] <= r_in_byte;
                end
            end
            for (int k = 0; k < srfc_pkg::WIN_DEPTH - 1; k++) begin
                r_win[k] <= r_win[k+1];
            end
            r_win[srfc_pkg::WIN_DEPTH-1] <= r_in_byte;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(srfc_pkg::MAX_FRAME))
        else $error("byte count beyond frame limit");

    a_frame_end_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $fell(r_in_frame)) |-> r_out_valid)
        else $error("frame closed without a status item");

    a_zero_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status != srfc_pkg::ST_TOUCH
                     && r_out_status != srfc_pkg::ST_PAGE) |-> (r_out_data == '0))
        else $error("error status carries payload");

    a_stall_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> (r_in_valid && r_out_valid && !i_m_tready))
        else $error("input stalled without a blocked result");
`endif

endmodule
